/* sv/pott_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pott_pkg
// Shared types and constants of the periodic and one-shot timer table.
// ----------------------------------------------------------------------------
package pott_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ADD_PER = 2'd1,
    OP_ADD_ONE = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_REM  = 2'd1,
    KIND_FIRE = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PROC,
    ST_DONE
  } state_t;

  // One slot as stored in the slot memory.
  typedef struct packed {
    logic [15:0] interval;
    logic [15:0] countdown;
    logic [15:0] id;
  } slot_entry_t;

endpackage

/* sv/periodic_oneshot_timer_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_table
// Table of timer slots with periodic and one-shot tasks, scanned per tick.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid/in_ready) carries one word per
// operation: a tick, an add of a periodic or one-shot task, or a remove of a
// periodic task by id. The output channel (out_valid/out_ready) returns the
// result words: one answer for an add or a remove, and for a tick one word
// per fired task followed by a done marker that carries last.
// An add is answered from the idle state: its answer is registered on the
// accepting edge. A remove or a tick walks the slots one at a time through
// the slot memory, whose read is registered. A slot that takes part is read
// and, on a tick, then modified and written back; a slot that does not is
// skipped. A tick makes two passes (periodic slots, then one-shot slots); a
// remove looks at periodic slots only and ends at the first matching id.
// The next word is taken once the operation has finished and the output
// register is free.
// Reset clears the occupancy flags, the slot kinds and the id counter; the
// slot memory itself is not cleared, since a slot is read only once an add
// has written it. When the receiver stalls, the scan holds on the slot whose
// result waits, and the pending result stays in the output register.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] interval,
  input  logic [15:0] task_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] task_id_res,
  output logic        ok,
  output logic        last
);

  localparam logic [pott_pkg::IDX_W-1:0] LAST_IDX = pott_pkg::IDX_W'(pott_pkg::SLOTS - 1);

  // Occupancy and kind of every slot live in flip-flops so that the lowest
  // free slot is found at once and reset clears them.
  logic [pott_pkg::SLOTS-1:0] slot_valid;
  logic [pott_pkg::SLOTS-1:0] slot_periodic;
  logic [15:0]                next_id;

  // Slot memory: interval, countdown and id of each slot.
  pott_pkg::slot_entry_t slot_mem [pott_pkg::SLOTS];
  pott_pkg::slot_entry_t rd_entry;

  pott_pkg::state_t state, state_next;

  logic [pott_pkg::IDX_W-1:0] idx;       // slot under scan
  logic                       pass;      // 0: periodic pass, 1: one-shot pass
  logic                       cur_remove; // scan serves a remove, else a tick
  logic [15:0]                tid_q;

  logic                       out_free;
  logic                       accept;
  pott_pkg::op_t              op_in;
  logic                       is_add;
  logic                       any_free;
  logic [pott_pkg::IDX_W-1:0] free_idx;
  logic                       add_ok;

  // Control produced by the sequencer outputs block.
  logic                       mem_re;
  logic                       mem_we;
  logic [pott_pkg::IDX_W-1:0] mem_waddr;
  pott_pkg::slot_entry_t      mem_wdata;
  logic                       emit;
  pott_pkg::kind_t            emit_kind;
  logic [15:0]                emit_id;
  logic                       emit_ok;
  logic                       emit_last;
  logic                       clr_slot;
  logic                       step;
  logic                       finish;
  logic                       relevant;
  logic                       fire;
  logic                       at_end;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == pott_pkg::ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign op_in    = pott_pkg::op_t'(operation);
  assign is_add   = (op_in == pott_pkg::OP_ADD_PER) || (op_in == pott_pkg::OP_ADD_ONE);
  assign at_end   = (idx == LAST_IDX);

  // Lowest free slot.
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = pott_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        any_free = 1'b1;
        free_idx = pott_pkg::IDX_W'(i);
      end
    end
  end

  assign add_ok = any_free && (interval != 16'd0);

  // A slot takes part in the current pass when it is occupied and of the
  // kind that the pass serves; a remove only looks at periodic slots.
  assign relevant = slot_valid[idx] && (slot_periodic[idx] == !pass);
  assign fire     = (rd_entry.countdown <= 16'd1);

  // Sequencer outputs.
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = rd_entry;
    emit      = 1'b0;
    emit_kind = pott_pkg::KIND_ADD;
    emit_id   = 16'd0;
    emit_ok   = 1'b0;
    emit_last = 1'b0;
    clr_slot  = 1'b0;
    step      = 1'b0;
    finish    = 1'b0;
    case (state)
      pott_pkg::ST_IDLE: begin
        if (accept && is_add) begin
          emit      = 1'b1;
          emit_kind = pott_pkg::KIND_ADD;
          emit_id   = add_ok ? next_id : 16'd0;
          emit_ok   = add_ok;
          emit_last = 1'b1;
          mem_we    = add_ok;
          mem_waddr = free_idx;
          mem_wdata = '{interval: interval, countdown: interval, id: next_id};
        end
      end
      pott_pkg::ST_READ: begin
        mem_re = relevant;
        step   = !relevant;
      end
      pott_pkg::ST_PROC: begin
        if (cur_remove) begin
          if (rd_entry.id != tid_q) begin
            step = 1'b1;
          end else if (out_free) begin
            emit      = 1'b1;
            emit_kind = pott_pkg::KIND_REM;
            emit_id   = tid_q;
            emit_ok   = 1'b1;
            emit_last = 1'b1;
            clr_slot  = 1'b1;
            finish    = 1'b1;
          end
        end else if (!fire || out_free) begin
          mem_we              = 1'b1;
          mem_wdata.countdown = fire ? rd_entry.interval : (rd_entry.countdown - 16'd1);
          emit                = fire;
          emit_kind           = pott_pkg::KIND_FIRE;
          emit_id             = rd_entry.id;
          emit_ok             = 1'b1;
          clr_slot            = fire && pass;
          step                = 1'b1;
        end
      end
      pott_pkg::ST_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = cur_remove ? pott_pkg::KIND_REM : pott_pkg::KIND_DONE;
          emit_id   = cur_remove ? tid_q : 16'd0;
          emit_last = 1'b1;
          finish    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      pott_pkg::ST_IDLE: begin
        if (accept && !is_add) begin
          state_next = pott_pkg::ST_READ;
        end
      end
      pott_pkg::ST_READ, pott_pkg::ST_PROC: begin
        if (finish) begin
          state_next = pott_pkg::ST_IDLE;
        end else if (mem_re) begin
          state_next = pott_pkg::ST_PROC;
        end else if (step) begin
          if (!at_end || (!cur_remove && !pass)) begin
            state_next = pott_pkg::ST_READ;
          end else begin
            state_next = pott_pkg::ST_DONE;
          end
        end
      end
      pott_pkg::ST_DONE: begin
        if (finish) begin
          state_next = pott_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pott_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pott_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan position and operation context.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pass       <= 1'b0;
      cur_remove <= 1'b0;
    end else if (accept && !is_add) begin
      idx        <= '0;
      pass       <= 1'b0;
      cur_remove <= (op_in == pott_pkg::OP_REMOVE);
    end else if (step) begin
      if (!at_end) begin
        idx <= idx + 1'b1;
      end else begin
        idx  <= '0;
        pass <= !cur_remove && !pass;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tid_q <= task_id;
    end
  end

  // Slot flags and id counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      slot_periodic <= '0;
      next_id       <= 16'd0;
    end else begin
      if (accept && is_add && add_ok) begin
        slot_valid[free_idx]    <= 1'b1;
        slot_periodic[free_idx] <= (op_in == pott_pkg::OP_ADD_PER);
        next_id                 <= next_id + 16'd1;
      end
      if (clr_slot) begin
        slot_valid[idx] <= 1'b0;
      end
    end
  end

  // Slot memory with a registered read port. Reads and writes of the scan
  // never overlap on one entry: a slot is read, then, on a tick, written back
  // before the next slot is read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_entry <= slot_mem[idx];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind        <= emit_kind;
      task_id_res <= emit_id;
      ok          <= emit_ok;
      last        <= emit_last;
    end
  end

`ifndef NO_ASSERTIONS
  // A fire report is never the closing word of a tick.
  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == pott_pkg::KIND_FIRE)) |-> !last)
    else $error("fire report marked last");

  // An accepted add with a nonzero interval and a free slot takes one slot.
  a_add_takes_slot: assert property (@(posedge clk) disable iff (rst)
    (accept && is_add && (interval != 16'd0) && !(&slot_valid)) |=>
    ($countones(slot_valid) == $past($countones(slot_valid)) + 1))
    else $error("add did not occupy exactly one slot");

  // The one-shot pass belongs only to a tick.
  a_pass_tick_only: assert property (@(posedge clk) disable iff (rst)
    (pass && (state != pott_pkg::ST_IDLE)) |-> !cur_remove)
    else $error("one-shot pass during a remove");

  // The scan writes the memory only while it processes a slot it has read.
  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state != pott_pkg::ST_IDLE)) |-> (state == pott_pkg::ST_PROC))
    else $error("slot memory written outside the modify step");
`endif

endmodule
